// ===== design/moving_sphere_impact_time_macros.svh =====
// assertion macros shared by the checker
`ifndef MOVING_SPHERE_IMPACT_TIME_MACROS_SVH
`define MOVING_SPHERE_IMPACT_TIME_MACROS_SVH

// checked only outside reset
`define MSIT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("msit check failed");

// checked at every edge, reset included
`define MSIT_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("msit check failed");

`endif

// ===== design/msit_pkg.sv =====
package msit_pkg;

	localparam int COORD_WIDTH    = 24;
	localparam int TIME_FRAC_BITS = 16;
	localparam int RAD_W          = 20;
	localparam int CFG_W          = 16;

	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int SS_W   = SQ_W + 2;
	localparam int MSQ_W  = 2 * COORD_WIDTH;
	localparam int A_W    = MSQ_W + 2;
	localparam int PRD_W  = DIFF_W + COORD_WIDTH;
	localparam int B_W    = PRD_W + 2;
	localparam int R_W    = RAD_W + 1;
	localparam int RR_W   = 2 * R_W;
	localparam int D_W    = 2 * SS_W;
	localparam int ROOT_W = SS_W;
	localparam int SPLIT  = (SS_W + 1) / 2;
	localparam int HI_W   = SS_W - SPLIT;
	localparam int PP_W   = 2 * SPLIT;
	localparam int TIME_W = TIME_FRAC_BITS + 1;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] first_x;
		logic signed [COORD_WIDTH-1:0] first_y;
		logic signed [COORD_WIDTH-1:0] first_z;
		logic [RAD_W-1:0]              first_radius;
		logic signed [COORD_WIDTH-1:0] second_x;
		logic signed [COORD_WIDTH-1:0] second_y;
		logic signed [COORD_WIDTH-1:0] second_z;
		logic [RAD_W-1:0]              second_radius;
		logic signed [COORD_WIDTH-1:0] move_x;
		logic signed [COORD_WIDTH-1:0] move_y;
		logic signed [COORD_WIDTH-1:0] move_z;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic              overlap_at_start;
		logic [TIME_W-1:0] impact_time;
	} rsp_t;

	// per-item flags and operands that ride alongside the square root
	typedef struct packed {
		logic            overlap;
		logic            kill;
		logic [SS_W-1:0] bmag;
		logic [SS_W-1:0] a;
	} side_t;

endpackage

// ===== design/msit_front.sv =====
module msit_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [msit_pkg::CFG_W-1:0]  min_motion_sq,
	input  logic                        in_valid,
	input  msit_pkg::req_t              req,
	output logic                        out_valid,
	output logic [msit_pkg::D_W-1:0]    d,
	output msit_pkg::side_t             side
);
	import msit_pkg::*;

	logic                          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [DIFF_W-1:0]      sd_s1 [3];
	logic signed [COORD_WIDTH-1:0] m_s1 [3];
	logic [R_W-1:0]                r_s1;
	logic [SQ_W-1:0]               sq_s2 [3];
	logic [MSQ_W-1:0]              mq_s2 [3];
	logic signed [PRD_W-1:0]       pm_s2 [3];
	logic [RR_W-1:0]               rr_s2;
	logic [SS_W-1:0]               ss_s3;
	logic [A_W-1:0]                a_s3;
	logic signed [B_W-1:0]         b_s3;
	logic [RR_W-1:0]               rr_s3;
	logic                          ovl_s4, kill_s4;
	logic [SS_W-1:0]               c_s4, bmag_s4, a_s4;
	logic                          ovl_s5, kill_s5;
	logic [SS_W-1:0]               bmag_s5, a_s5;
	logic [PP_W-1:0]               bll_s5, blh_s5, bhh_s5;
	logic [PP_W-1:0]               all_s5, alh_s5, ahl_s5, ahh_s5;
	logic                          ovl_s6, kill_s6;
	logic [SS_W-1:0]               bmag_s6, a_s6;
	logic [D_W-1:0]                bb_s6, ac_s6;
	logic                          ovl_s7, kill_s7;
	logic [SS_W-1:0]               bmag_s7, a_s7;
	logic [D_W-1:0]                d_s7;

	logic signed [SQ_W-1:0]  sdx [3];
	logic signed [MSQ_W-1:0] mx [3];
	logic signed [PRD_W-1:0] psd [3];
	logic signed [PRD_W-1:0] pm [3];
	logic [B_W-1:0]          nb;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sdx[i] = SQ_W'(sd_s1[i]);
			mx[i]  = MSQ_W'(m_s1[i]);
			psd[i] = PRD_W'(sd_s1[i]);
			pm[i]  = PRD_W'(m_s1[i]);
		end
		nb = B_W'(-b_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// centre offsets and summed radius
			sd_s1[0] <= DIFF_W'(req.first_x) - DIFF_W'(req.second_x);
			sd_s1[1] <= DIFF_W'(req.first_y) - DIFF_W'(req.second_y);
			sd_s1[2] <= DIFF_W'(req.first_z) - DIFF_W'(req.second_z);
			m_s1[0]  <= req.move_x;
			m_s1[1]  <= req.move_y;
			m_s1[2]  <= req.move_z;
			r_s1     <= R_W'(req.first_radius) + R_W'(req.second_radius);

			// per-axis products
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= SQ_W'(sdx[i] * sdx[i]);
				mq_s2[i] <= MSQ_W'(mx[i] * mx[i]);
				pm_s2[i] <= psd[i] * pm[i];
			end
			rr_s2 <= RR_W'(r_s1) * RR_W'(r_s1);

			// dot products
			ss_s3 <= SS_W'(sq_s2[0]) + SS_W'(sq_s2[1]) + SS_W'(sq_s2[2]);
			a_s3  <= A_W'(mq_s2[0]) + A_W'(mq_s2[1]) + A_W'(mq_s2[2]);
			b_s3  <= B_W'(pm_s2[0]) + B_W'(pm_s2[1]) + B_W'(pm_s2[2]);
			rr_s3 <= rr_s2;

			// overlap, c, early rejects
			ovl_s4  <= ss_s3 < SS_W'(rr_s3);
			c_s4    <= ss_s3 - SS_W'(rr_s3);
			kill_s4 <= (a_s3 < A_W'(min_motion_sq)) || !b_s3[B_W-1];
			bmag_s4 <= SS_W'(nb);
			a_s4    <= SS_W'(a_s3);

			// partial products of b*b and a*c
			ovl_s5  <= ovl_s4;
			kill_s5 <= kill_s4;
			bmag_s5 <= bmag_s4;
			a_s5    <= a_s4;
			bll_s5  <= PP_W'(bmag_s4[SPLIT-1:0]) * PP_W'(bmag_s4[SPLIT-1:0]);
			blh_s5  <= PP_W'(bmag_s4[SPLIT-1:0]) * PP_W'(bmag_s4[SS_W-1:SPLIT]);
			bhh_s5  <= PP_W'(bmag_s4[SS_W-1:SPLIT]) * PP_W'(bmag_s4[SS_W-1:SPLIT]);
			all_s5  <= PP_W'(a_s4[SPLIT-1:0]) * PP_W'(c_s4[SPLIT-1:0]);
			alh_s5  <= PP_W'(a_s4[SPLIT-1:0]) * PP_W'(c_s4[SS_W-1:SPLIT]);
			ahl_s5  <= PP_W'(a_s4[SS_W-1:SPLIT]) * PP_W'(c_s4[SPLIT-1:0]);
			ahh_s5  <= PP_W'(a_s4[SS_W-1:SPLIT]) * PP_W'(c_s4[SS_W-1:SPLIT]);

			ovl_s6  <= ovl_s5;
			kill_s6 <= kill_s5;
			bmag_s6 <= bmag_s5;
			a_s6    <= a_s5;
			bb_s6   <= (D_W'(bhh_s5) << (2 * SPLIT)) + (D_W'(blh_s5) << (SPLIT + 1))
				+ D_W'(bll_s5);
			ac_s6   <= (D_W'(ahh_s5) << (2 * SPLIT)) + (D_W'(alh_s5) << SPLIT)
				+ (D_W'(ahl_s5) << SPLIT) + D_W'(all_s5);

			// discriminant
			ovl_s7  <= ovl_s6;
			kill_s7 <= kill_s6 || (bb_s6 < ac_s6);
			bmag_s7 <= bmag_s6;
			a_s7    <= a_s6;
			d_s7    <= bb_s6 - ac_s6;
		end
	end

	assign out_valid    = v_s7;
	assign d            = d_s7;
	assign side.overlap = ovl_s7;
	assign side.kill    = kill_s7;
	assign side.bmag    = bmag_s7;
	assign side.a       = a_s7;

endmodule

// ===== design/msit_sqrt.sv =====
module msit_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [msit_pkg::D_W-1:0]      d,
	input  msit_pkg::side_t               side_in,
	output logic                          out_valid,
	output logic [msit_pkg::ROOT_W-1:0]   root,
	output msit_pkg::side_t               side_out
);
	import msit_pkg::*;

	localparam int REM_W = ROOT_W + 3;

	logic              v_s [ROOT_W+1];
	logic [REM_W-1:0]  rem_s [ROOT_W+1];
	logic [ROOT_W-1:0] root_s [ROOT_W+1];
	logic [D_W-1:0]    dsh_s [ROOT_W+1];
	side_t             side_s [ROOT_W+1];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign dsh_s[0]  = d;
	assign side_s[0] = side_in;

	// one root bit per stage, two radicand bits shifted in each time
	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic [REM_W-1:0] cur, trial;
		logic             ge;

		assign cur   = {rem_s[k][REM_W-3:0], dsh_s[k][D_W-1 -: 2]};
		assign trial = REM_W'({root_s[k], 2'b01});
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? cur - trial : cur;
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
				dsh_s[k+1]  <= dsh_s[k] << 2;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign root      = root_s[ROOT_W];
	assign side_out  = side_s[ROOT_W];

endmodule

// ===== design/msit_div.sv =====
module msit_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [msit_pkg::ROOT_W-1:0]  root,
	input  msit_pkg::side_t              side,
	output logic                         out_valid,
	output msit_pkg::rsp_t               rsp
);
	import msit_pkg::*;

	localparam int REM_W = SS_W + 1;

	logic              v_p, ovl_p, kill_p;
	logic [SS_W-1:0]   n_p, a_p;
	logic [SS_W-1:0]   n;

	logic              v_s [TIME_W+1];
	logic              ovl_s [TIME_W+1];
	logic              kill_s [TIME_W+1];
	logic [REM_W-1:0]  rem_s [TIME_W+1];
	logic [SS_W-1:0]   a_s [TIME_W+1];
	logic [TIME_W-1:0] q_s [TIME_W+1];

	assign n = side.bmag - root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= 1'b0;
		end else if (en) begin
			v_p <= in_valid;
		end
	end

	// numerator and the beyond-one-step check
	always_ff @(posedge clk) begin
		if (en) begin
			n_p    <= n;
			a_p    <= side.a;
			ovl_p  <= side.overlap;
			kill_p <= side.kill || (n > side.a);
		end
	end

	assign v_s[0]    = v_p;
	assign ovl_s[0]  = ovl_p;
	assign kill_s[0] = kill_p;
	assign rem_s[0]  = REM_W'(n_p);
	assign a_s[0]    = a_p;
	assign q_s[0]    = '0;

	// restoring division, integer bit first then one fraction bit per stage
	for (genvar j = 0; j < TIME_W; j++) begin : g_stage
		logic [REM_W-1:0] t;
		logic             ge;

		if (j == 0) begin : g_int
			assign t = rem_s[j];
		end else begin : g_frac
			assign t = {rem_s[j][REM_W-2:0], 1'b0};
		end
		assign ge = t >= REM_W'(a_s[j]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? t - REM_W'(a_s[j]) : t;
				q_s[j+1]    <= {q_s[j][TIME_W-2:0], ge};
				a_s[j+1]    <= a_s[j];
				ovl_s[j+1]  <= ovl_s[j];
				kill_s[j+1] <= kill_s[j];
			end
		end
	end

	assign out_valid            = v_s[TIME_W];
	assign rsp.hit              = ovl_s[TIME_W] || !kill_s[TIME_W];
	assign rsp.overlap_at_start = ovl_s[TIME_W];
	assign rsp.impact_time      = (ovl_s[TIME_W] || kill_s[TIME_W]) ? '0 : q_s[TIME_W];

endmodule

// ===== design/moving_sphere_impact_time.sv =====
// channel  | direction | word     | handshake
// req      | in        | req_t    | req_valid / req_stall
// rsp      | out       | rsp_t    | rsp_valid / rsp_stall
// cfg      | in        | 16 bits  | cfg_we, no wait
//
// one word enters per cycle unless a stalled rsp freezes the pipe; words leave in order
// the pipe is 7 front stages, 52 square root stages, 1 numerator stage, 17 divide stages
// the square root takes one root bit per stage, which sets the depth
// arst_n clears all valid bits and sets min_motion_sq to 1
// a stalled rsp freezes the whole pipe; req_stall is raised only then
module moving_sphere_impact_time (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  msit_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output msit_pkg::rsp_t              rsp,
	input  logic                        cfg_we,
	input  logic [msit_pkg::CFG_W-1:0]  cfg_wdata
);
	import msit_pkg::*;

	logic [CFG_W-1:0]  min_motion_sq_q;
	logic              en;
	logic              f_valid, r_valid;
	logic [D_W-1:0]    f_d;
	side_t             f_side, r_side;
	logic [ROOT_W-1:0] r_root;

	// motion threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_motion_sq_q <= CFG_W'(1);
		end else if (cfg_we) begin
			min_motion_sq_q <= cfg_wdata;
		end
	end

	// the pipe moves unless a finished word sits unaccepted at the output
	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	// offsets, dot products and discriminant
	msit_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.min_motion_sq (min_motion_sq_q),
		.in_valid      (req_valid),
		.req           (req),
		.out_valid     (f_valid),
		.d             (f_d),
		.side          (f_side)
	);

	// integer square root of the discriminant
	msit_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.d         (f_d),
		.side_in   (f_side),
		.out_valid (r_valid),
		.root      (r_root),
		.side_out  (r_side)
	);

	// b magnitude minus root over a as a fraction of the step, last stage is the output register
	msit_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (r_valid),
		.root      (r_root),
		.side      (r_side),
		.out_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// ===== design/msit_checker.sv =====
`include "moving_sphere_impact_time_macros.svh"

module msit_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input msit_pkg::rsp_t rsp
);

	// a held word stays put
	`MSIT_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))

	// input backs up only behind a stalled output word
	`MSIT_ASSERT_ALWAYS(a_stall_cause, clk, req_stall == (rsp_valid && rsp_stall))

	// overlap is always a hit at time zero
	`MSIT_ASSERT(a_overlap, clk, arst_n, rsp_valid && rsp.overlap_at_start |-> rsp.hit && rsp.impact_time == 0)

	// a miss carries no time and no overlap
	`MSIT_ASSERT(a_miss, clk, arst_n, rsp_valid && !rsp.hit |-> rsp.impact_time == 0 && !rsp.overlap_at_start)

endmodule

bind moving_sphere_impact_time msit_checker u_msit_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ===== bench/msit_checker.sv =====
`timescale 1ns / 1ps

// watches the req, rsp and cfg channels, predicts each rsp word and compares
module msit_scoreboard (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_stall,
	input  msit_pkg::req_t             req,
	input  logic                       rsp_valid,
	input  logic                       rsp_stall,
	input  msit_pkg::rsp_t             rsp,
	input  logic                       cfg_we,
	input  logic [msit_pkg::CFG_W-1:0] cfg_wdata,
	output int                         errors,
	output int                         pending,
	output int                         checked_words,
	output int                         hit_words,
	output int                         overlap_words
);
	import msit_pkg::*;

	logic [CFG_W-1:0] motion_floor;
	rsp_t             contact_q[$];

	function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
		logic [63:0]  root;
		logic [63:0]  trial;
		logic [127:0] sq;
		root = '0;
		for (int k = 63; k >= 0; k--) begin
			trial = root | (64'd1 << k);
			sq = {64'd0, trial} * {64'd0, trial};
			if (sq <= v)
				root = trial;
		end
		return root;
	endfunction

	function automatic rsp_t predict_contact(input req_t w, input logic [CFG_W-1:0] floor_sq);
		longint           s[3];
		longint           m[3];
		longint           b;
		longint unsigned  ss, mm2, rsum, rr, c, bmag, n;
		logic [127:0]     bb, ac, disc, num;
		rsp_t             o;
		o = '0;
		s[0] = longint'(w.first_x) - longint'(w.second_x);
		s[1] = longint'(w.first_y) - longint'(w.second_y);
		s[2] = longint'(w.first_z) - longint'(w.second_z);
		m[0] = longint'(w.move_x);
		m[1] = longint'(w.move_y);
		m[2] = longint'(w.move_z);
		ss = 0;
		mm2 = 0;
		b = 0;
		for (int k = 0; k < 3; k++) begin
			ss += longint'(s[k] * s[k]);
			mm2 += longint'(m[k] * m[k]);
			b += s[k] * m[k];
		end
		rsum = longint'(w.first_radius) + longint'(w.second_radius);
		rr = rsum * rsum;
		// already interpenetrating
		if (ss < rr) begin
			o.hit = 1'b1;
			o.overlap_at_start = 1'b1;
			return o;
		end
		c = ss - rr;
		// too slow to count as moving, or not closing in
		if (mm2 < longint'(floor_sq) || b >= 0 || mm2 == 0)
			return o;
		bmag = -b;
		bb = {64'd0, bmag} * {64'd0, bmag};
		ac = {64'd0, mm2} * {64'd0, c};
		// paths never meet
		if (bb < ac)
			return o;
		disc = bb - ac;
		n = bmag - floor_sqrt(disc);
		// first contact lies past the end of the step
		if (n > mm2)
			return o;
		num = {64'd0, n} << TIME_FRAC_BITS;
		o.hit = 1'b1;
		o.impact_time = TIME_W'(num / {64'd0, mm2});
		return o;
	endfunction

	assign pending = contact_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_floor <= CFG_W'(1);
			contact_q.delete();
			errors <= 0;
			checked_words <= 0;
			hit_words <= 0;
			overlap_words <= 0;
		end else begin
			if (cfg_we)
				motion_floor <= cfg_wdata;
			if (req_valid && !req_stall)
				contact_q.push_back(predict_contact(req, motion_floor));
			if (rsp_valid && !rsp_stall) begin
				if (contact_q.size() == 0) begin
					$error("rsp word with nothing expected: %p", rsp);
					errors <= errors + 1;
				end else begin
					rsp_t e;
					int   bad;
					e = contact_q.pop_front();
					bad = 0;
					if (rsp.hit !== e.hit) begin
						$error("hit: expected %0d actual %0d", e.hit, rsp.hit);
						bad++;
					end
					if (rsp.overlap_at_start !== e.overlap_at_start) begin
						$error("overlap_at_start: expected %0d actual %0d",
							e.overlap_at_start, rsp.overlap_at_start);
						bad++;
					end
					if (rsp.impact_time !== e.impact_time) begin
						$error("impact_time: expected %0d actual %0d",
							e.impact_time, rsp.impact_time);
						bad++;
					end
					errors <= errors + bad;
					checked_words <= checked_words + 1;
					hit_words <= hit_words + e.hit;
					overlap_words <= overlap_words + e.overlap_at_start;
				end
			end
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import msit_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int PIPE_DRAIN  = 90;
	localparam int PHASE_WORDS = 220;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_stall;
	rsp_t             rsp;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	int  errors, pending, checked_words, hit_words, overlap_words;
	int  cycles;
	int  words_sent;
	bit  steady;        // when set neither side idles
	int  rsp_hold;

	moving_sphere_impact_time dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	msit_scoreboard chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.errors        (errors),
		.pending       (pending),
		.checked_words (checked_words),
		.hit_words     (hit_words),
		.overlap_words (overlap_words)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run-away guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// rsp back-pressure: bursts, mostly short, now and then long
	always @(posedge clk) begin
		if (steady) begin
			rsp_stall <= 1'b0;
		end else if (rsp_hold > 0) begin
			rsp_hold = rsp_hold - 1;
			rsp_stall <= 1'b1;
		end else if ($urandom_range(0, 3) == 0) begin
			rsp_hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 40);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	function automatic req_t make_word(input int fx, fy, fz, fr, sx, sy, sz, sr, mx, my, mz);
		req_t w;
		w.first_x = COORD_WIDTH'(fx);
		w.first_y = COORD_WIDTH'(fy);
		w.first_z = COORD_WIDTH'(fz);
		w.first_radius = RAD_W'(fr);
		w.second_x = COORD_WIDTH'(sx);
		w.second_y = COORD_WIDTH'(sy);
		w.second_z = COORD_WIDTH'(sz);
		w.second_radius = RAD_W'(sr);
		w.move_x = COORD_WIDTH'(mx);
		w.move_y = COORD_WIDTH'(my);
		w.move_z = COORD_WIDTH'(mz);
		return w;
	endfunction

	// signed value of about 2^(bits-1) magnitude
	function automatic int rand_signed(input int bits);
		int v;
		v = int'($urandom & ((32'd1 << bits) - 1));
		return v - (1 << (bits - 1));
	endfunction

	// mostly plausible encounters: move heads roughly at the other sphere
	function automatic req_t random_word();
		req_t  w;
		int    mag, fx, fy, fz, sx, sy, sz, ms, mix;
		longint dx, dy, dz;
		if ($urandom_range(0, 7) == 0) begin
			// raw bits, reaches every bit of every field
			w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom};
			return w;
		end
		mag = $urandom_range(4, 22);
		fx = rand_signed(mag); fy = rand_signed(mag); fz = rand_signed(mag);
		sx = rand_signed(mag); sy = rand_signed(mag); sz = rand_signed(mag);
		mix = $urandom_range(0, 16);
		dx = longint'(sx - fx) * mix / 8 + rand_signed(mag > 6 ? mag - 3 : 3);
		dy = longint'(sy - fy) * mix / 8 + rand_signed(mag > 6 ? mag - 3 : 3);
		dz = longint'(sz - fz) * mix / 8 + rand_signed(mag > 6 ? mag - 3 : 3);
		ms = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) : mag;
		w = make_word(fx, fy, fz, int'($urandom & ((32'd1 << ms) - 1)),
			sx, sy, sz, int'($urandom & ((32'd1 << ms) - 1)),
			int'(dx), int'(dy), int'(dz));
		// sometimes a tiny move, to sit near the motion floor
		if ($urandom_range(0, 9) == 0) begin
			w.move_x = COORD_WIDTH'(rand_signed(8));
			w.move_y = COORD_WIDTH'(rand_signed(6));
			w.move_z = COORD_WIDTH'(rand_signed(4));
		end
		return w;
	endfunction

	task automatic send_word(input req_t w);
		int  gap;
		bit  held;
		gap = steady ? 0 :
			(($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(6, 40));
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		// stall only moves on clock edges, so the mid-cycle value is the one sampled
		do begin
			@(negedge clk);
			held = req_stall;
			@(posedge clk);
		end while (held);
		words_sent++;
	endtask

	task automatic write_min_motion(input logic [CFG_W-1:0] v);
		req_valid <= 1'b0;
		wait (pending == 0);
		repeat (PIPE_DRAIN) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [CFG_W-1:0] floors[5];
		cycles = 0;
		words_sent = 0;
		rsp_hold = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at the reset floor, 256 is one unit
		send_word(make_word(0, 0, 0, 256, 256, 0, 0, 256, 0, 0, 0));       // overlapping
		send_word(make_word(0, 0, 0, 256, 512, 0, 0, 256, 256, 0, 0));     // touching, closing
		send_word(make_word(0, 0, 0, 256, 512, 0, 0, 256, -256, 0, 0));    // touching, parting
		send_word(make_word(0, 0, 0, 256, 5000, 0, 0, 256, 0, 0, 0));      // at rest
		send_word(make_word(0, 0, 0, 256, 2560, 0, 0, 256, 0, 2560, 0));   // sideways, b zero
		send_word(make_word(0, 0, 0, 256, 2560, 0, 0, 256, 512, 2560, 0)); // near miss
		send_word(make_word(0, 0, 0, 256, 25600, 0, 0, 256, 256, 0, 0));  // contact after the step
		send_word(make_word(0, 0, 0, 128, 1024, 0, 0, 128, 768, 0, 0));    // contact at exactly one
		send_word(make_word(0, 0, 0, 128, 1024, 0, 0, 128, 1536, 0, 0));   // contact at one half
		send_word(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));             // all zero
		send_word(make_word(0, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0));             // point masses meeting
		send_word(make_word(8388607, 8388607, 8388607, 1048575, -8388608, -8388608, -8388608,
			1048575, -8388608, -8388608, -8388608));                   // widest span, fast
		send_word(make_word(-8388608, -8388608, -8388608, 0, 8388607, 8388607, 8388607, 0,
			8388607, 8388607, 8388607));
		send_word(make_word(8388607, 0, -8388608, 1048575, 0, 0, 0, 1048575, 0, 0, 0));
		send_word(make_word(-8388608, 8388607, 0, 0, 8388607, -8388608, 0, 0,
			8388607, -8388608, 0));
		send_word(make_word(0, 0, 0, 1048575, 0, 0, 0, 1048575, 8388607, 8388607, 8388607));

		// random phases across several motion floors, extremes included
		floors[0] = 16'd1;
		floors[1] = 16'd0;
		floors[2] = 16'hFFFF;
		floors[3] = CFG_W'($urandom);
		floors[4] = 16'd256;
		for (int p = 0; p < 5; p++) begin
			write_min_motion(floors[p]);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				// an unthrottled stretch in every phase
				steady = (i >= 60 && i < 100);
				send_word(random_word());
			end
			steady = 1'b0;
		end
		req_valid <= 1'b0;

		wait (pending == 0);
		repeat (PIPE_DRAIN) @(posedge clk);
		$display("sent %0d words over 5 motion floors, checked %0d rsp words", words_sent,
			checked_words);
		$display("%0d predicted contacts, %0d of them interpenetrating at the start", hit_words,
			overlap_words);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
